/* design/idf2_pkg.sv */
// idf2_pkg: widths, register indexes, control struct and rounding helper
// for the direct form II IIR filter. No dependencies.
`default_nettype none

package idf2_pkg;

    localparam int SMP_W   = 24;               // Q1.23 sample
    localparam int COEF_W  = 24;               // Q4.20 tap
    localparam int DLY_W   = 32;               // Q9.23 delay entry
    localparam int FRAC_SH = 20;               // 43 -> 23 fraction bits
    localparam int PROD_W  = COEF_W + DLY_W;   // exact tap product
    localparam int ACC_W   = 60;               // headroom for four products
    localparam int RND_W   = ACC_W - FRAC_SH;  // accumulator after rounding

    localparam int REG_IDX_W = 3;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_B0 = 3'd0;
    localparam t_reg_idx REG_B1 = 3'd1;
    localparam t_reg_idx REG_B2 = 3'd2;
    localparam t_reg_idx REG_B3 = 3'd3;
    localparam t_reg_idx REG_A1 = 3'd4;
    localparam t_reg_idx REG_A2 = 3'd5;
    localparam t_reg_idx REG_A3 = 3'd6;

    localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd1048576;  // 1.0

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [DLY_W-1:0]  t_dly;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [RND_W-1:0]  t_rnd;

    // Request to the shared multiply-accumulate unit
    typedef struct packed {
        logic load;   // start a sample: v acc = x aligned, y acc = 0
        logic mul;    // issue coef * data this cycle
        logic to_y;   // add into y acc; otherwise subtract from v acc
    } t_mac_ctl;

    // Add half an LSB, then floor (round half toward plus infinity)
    function automatic t_rnd rnd20(input t_acc acc);
        t_acc t;
        t = acc + (t_acc'(1) <<< (FRAC_SH - 1));
        return t_rnd'(t >>> FRAC_SH);
    endfunction

endpackage

`default_nettype wire

/* design/idf2_in_if.sv */
// idf2_in_if: input sample channel (valid/ready plus Q1.23 sample).
// Depends on idf2_pkg.
`default_nettype none

interface idf2_in_if;
    import idf2_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* design/idf2_out_if.sv */
// idf2_out_if: filtered sample channel (valid/ready, sample and clip flag).
// Depends on idf2_pkg.
`default_nettype none

interface idf2_out_if;
    import idf2_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  sample_out;
    logic                     clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

/* design/idf2_mac.sv */
// idf2_mac: shared 24x32 multiplier with a registered product, feeding the
// recursive (v) and output (y) accumulators. Depends on idf2_pkg.
`default_nettype none

module idf2_mac (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire idf2_pkg::t_mac_ctl         i_ctl,
    input  wire logic signed [23:0]         i_x,
    input  wire idf2_pkg::t_coef            i_coef,
    input  wire idf2_pkg::t_dly             i_data,
    output idf2_pkg::t_acc                  o_vacc,
    output idf2_pkg::t_acc                  o_yacc
);
    import idf2_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_acc_en;
    logic                     r_to_y;
    t_acc                     r_vacc;
    t_acc                     r_yacc;
    t_acc                     prod_ext;
    t_acc                     acc_sel;
    t_acc                     acc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_ctl.mul;
        end
    end

    // operands sign extended to the full product width before the multiply
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(i_coef) * PROD_W'(i_data);
            r_to_y <= i_ctl.to_y;
        end
    end

    // one adder shared by both accumulators
    assign prod_ext = t_acc'(r_prod);
    assign acc_sel  = r_to_y ? r_yacc : r_vacc;
    assign acc_sum  = r_to_y ? (acc_sel + prod_ext) : (acc_sel - prod_ext);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_vacc <= {{(ACC_W - SMP_W - FRAC_SH){i_x[SMP_W-1]}}, i_x, {FRAC_SH{1'b0}}};
            r_yacc <= '0;
        end else if (r_acc_en) begin
            if (r_to_y) begin
                r_yacc <= acc_sum;
            end else begin
                r_vacc <= acc_sum;
            end
        end
    end

    assign o_vacc = r_vacc;
    assign o_yacc = r_yacc;

endmodule

`default_nettype wire

/* design/iir_direct_form_two.sv */
// iir_direct_form_two: direct form II IIR filter, order ORDER (1..3).
// The a taps, the b taps and then b0 * v pass in turn through the single
// multiplier; the rounded y is registered as the output and waits while the
// output channel stalls. A new sample is taken only once the last one is done,
// since the single multiplier takes every tap product in turn.
// Reset: synchronous; coefficients to b0 = 1.0, all others 0, delay line zero.
`default_nettype none

module iir_direct_form_two #(
    parameter int ORDER = 3
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire idf2_pkg::t_reg_idx     i_cfg_idx,
    input  wire logic [23:0]            i_cfg_data,
    idf2_in_if.sink                     i_smp,
    idf2_out_if.source                  o_smp
);
    import idf2_pkg::*;

    localparam int VRND_STEP = ORDER + 1;
    localparam int B0_STEP   = (2 * ORDER > ORDER + 2) ? 2 * ORDER : ORDER + 2;
    localparam int YRND_STEP = B0_STEP + 2;
    localparam int STEP_W    = $clog2(YRND_STEP + 1);
    localparam int TAP_W     = (ORDER > 1) ? $clog2(ORDER) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic               r_state;
    logic [STEP_W-1:0]  r_step;

    t_coef              r_b0;
    t_coef              r_bcoef [ORDER];
    t_coef              r_acoef [ORDER];
    t_dly               r_dly   [ORDER];

    logic signed [SMP_W-1:0] r_x;
    t_dly               r_v;
    logic               r_clip;

    logic               r_out_valid;
    logic signed [SMP_W-1:0] r_out_smp;
    logic               r_out_clip;

    logic               accept;
    logic               is_a_step;
    logic               is_b_step;
    logic               is_b0_step;
    logic               is_vrnd;
    logic               is_yrnd;
    logic               out_free;
    logic               finish;
    logic [STEP_W-1:0]  b_off;
    logic [TAP_W-1:0]   tap;

    t_mac_ctl           mac_ctl;
    t_coef              mac_coef;
    t_dly               mac_data;
    t_acc               vacc;
    t_acc               yacc;

    t_rnd               v_rnd;
    t_rnd               y_rnd;
    logic               v_ovf;
    logic               y_ovf;
    t_dly               v_sat;
    logic signed [SMP_W-1:0] y_sat;

    assign accept   = i_smp.valid && i_smp.ready;
    assign out_free = !r_out_valid || o_smp.ready;

    assign is_a_step  = (r_state == S_RUN) && (r_step < STEP_W'(ORDER));
    assign is_b_step  = (r_state == S_RUN) && !is_a_step && (r_step < STEP_W'(2 * ORDER));
    assign is_b0_step = (r_state == S_RUN) && (r_step == STEP_W'(B0_STEP));
    assign is_vrnd    = (r_state == S_RUN) && (r_step == STEP_W'(VRND_STEP));
    assign is_yrnd    = (r_state == S_RUN) && (r_step == STEP_W'(YRND_STEP));
    assign finish     = is_yrnd && out_free;

    assign b_off = r_step - STEP_W'(ORDER);
    assign tap   = is_a_step ? r_step[TAP_W-1:0] : b_off[TAP_W-1:0];

    // a taps first so v is rounded while the b taps still run (ORDER above 1)
    always_comb begin
        mac_ctl.load = accept;
        mac_ctl.mul  = is_a_step || is_b_step || is_b0_step;
        mac_ctl.to_y = !is_a_step;
        if (is_a_step) begin
            mac_coef = r_acoef[tap];
            mac_data = r_dly[tap];
        end else if (is_b_step) begin
            mac_coef = r_bcoef[tap];
            mac_data = r_dly[tap];
        end else begin
            mac_coef = r_b0;
            mac_data = r_v;
        end
    end

    idf2_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_x     (i_smp.sample_in),
        .i_coef  (mac_coef),
        .i_data  (mac_data),
        .o_vacc  (vacc),
        .o_yacc  (yacc)
    );

    // round, then saturate when the dropped high bits are not all sign
    assign v_rnd = rnd20(vacc);
    assign y_rnd = rnd20(yacc);
    assign v_ovf = !(&v_rnd[RND_W-1:DLY_W-1]) && (|v_rnd[RND_W-1:DLY_W-1]);
    assign y_ovf = !(&y_rnd[RND_W-1:SMP_W-1]) && (|y_rnd[RND_W-1:SMP_W-1]);
    assign v_sat = !v_ovf ? v_rnd[DLY_W-1:0]
                 : (v_rnd[RND_W-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}});
    assign y_sat = !y_ovf ? y_rnd[SMP_W-1:0]
                 : (y_rnd[RND_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}});

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else if (r_state == S_IDLE) begin
            if (accept) begin
                r_state <= S_RUN;
                r_step  <= '0;
            end
        end else if (finish) begin
            r_state <= S_IDLE;
        end else if (!is_yrnd) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    // coefficients and delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_RESET;
            for (int k = 0; k < ORDER; k++) begin
                r_bcoef[k] <= '0;
                r_acoef[k] <= '0;
                r_dly[k]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_B0) begin
                    r_b0 <= i_cfg_data;
                end
                for (int k = 0; k < ORDER; k++) begin
                    if (i_cfg_idx == REG_B1 + t_reg_idx'(k)) begin
                        r_bcoef[k] <= i_cfg_data;
                    end
                    if (i_cfg_idx == REG_A1 + t_reg_idx'(k)) begin
                        r_acoef[k] <= i_cfg_data;
                    end
                end
            end
            if (finish) begin
                for (int k = ORDER - 1; k > 0; k--) begin
                    r_dly[k] <= r_dly[k-1];
                end
                r_dly[0] <= r_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_smp.sample_in;
        end
        if (is_vrnd) begin
            r_v    <= v_sat;
            r_clip <= v_ovf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_smp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_smp  <= y_sat;
            r_out_clip <= r_clip || y_ovf;
        end
    end

    assign i_smp.ready      = (r_state == S_IDLE);
    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out_smp;
    assign o_smp.clipped    = r_out_clip;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_smp.ready)
        else $error("new request taken while a sample is in flight");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RUN && r_step == STEP_W'(YRND_STEP)))
        else $error("output raised outside the final step");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |=> $stable(r_x) || accept)
        else $error("latched sample changed during processing");

endmodule

`default_nettype wire

/* tb/idf2_checker.sv */
// idf2_checker: watches the config port and both sample channels of
// iir_direct_form_two, predicts every filtered sample and compares it.
// Depends on idf2_pkg.
module idf2_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  idf2_pkg::t_reg_idx                i_cfg_idx,
    input  logic [idf2_pkg::COEF_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [idf2_pkg::SMP_W-1:0] i_in_sample,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [idf2_pkg::SMP_W-1:0] i_out_sample,
    input  logic                              i_out_clipped,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    import idf2_pkg::*;

    localparam longint DLY_MAX = 64'sd2147483647;
    localparam longint DLY_MIN = -64'sd2147483648;
    localparam longint SMP_MAX = 64'sd8388607;
    localparam longint SMP_MIN = -64'sd8388608;

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic                    clip;
    } t_filt_out;

    t_coef     coef_bank [0:6];
    t_dly      dly_line  [0:2];
    t_filt_out filtered_q [$];
    int        err_cnt;
    int        match_cnt;
    int        clip_cnt;

    // One direct form II step: recursion, output sum, then shift the delay line
    function automatic t_filt_out filter_sample(input logic signed [SMP_W-1:0] x);
        longint    v_acc;
        longint    y_acc;
        longint    v;
        longint    y;
        logic      hit;
        t_filt_out r;
        v_acc = longint'(x) <<< FRAC_SH;
        y_acc = 0;
        hit   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v_acc -= longint'(coef_bank[REG_A1 + k]) * longint'(dly_line[k]);
            y_acc += longint'(coef_bank[REG_B1 + k]) * longint'(dly_line[k]);
        end
        // add half an LSB then floor
        v = (v_acc + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH;
        if (v > DLY_MAX) begin
            v   = DLY_MAX;
            hit = 1'b1;
        end else if (v < DLY_MIN) begin
            v   = DLY_MIN;
            hit = 1'b1;
        end
        y_acc += longint'(coef_bank[REG_B0]) * v;
        y = (y_acc + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH;
        if (y > SMP_MAX) begin
            y   = SMP_MAX;
            hit = 1'b1;
        end else if (y < SMP_MIN) begin
            y   = SMP_MIN;
            hit = 1'b1;
        end
        dly_line[2] = dly_line[1];
        dly_line[1] = dly_line[0];
        dly_line[0] = t_dly'(v);
        r.smp  = y[SMP_W-1:0];
        r.clip = hit;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_filt_out want;
        if (!i_rst_n) begin
            foreach (coef_bank[k]) coef_bank[k] = '0;
            coef_bank[REG_B0] = B0_RESET;
            foreach (dly_line[k]) dly_line[k] = '0;
            filtered_q.delete();
            err_cnt   = 0;
            match_cnt = 0;
            clip_cnt  = 0;
        end else begin
            // result side first: a request accepted on this edge cannot be answered yet
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output sample %0d clipped %0b", $time,
                             i_out_sample, i_out_clipped);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_out_sample !== want.smp) begin
                        err_cnt++;
                        $display("%0t: sample_out mismatch: expected %0d, got %0d", $time,
                                 want.smp, i_out_sample);
                    end
                    if (i_out_clipped !== want.clip) begin
                        err_cnt++;
                        $display("%0t: clipped mismatch: expected %0b, got %0b", $time,
                                 want.clip, i_out_clipped);
                    end
                    match_cnt++;
                    if (want.clip)
                        clip_cnt++;
                end
            end
            if (i_in_valid && i_in_ready)
                filtered_q.insert(filtered_q.size(), filter_sample(i_in_sample));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3: begin
                        coef_bank[i_cfg_idx] = t_coef'(i_cfg_data);
                    end
                    default: ;
                endcase
            end
        end
        o_errors  <= err_cnt;
        o_pending <= filtered_q.size();
        o_checked <= match_cnt;
        o_clipped <= clip_cnt;
    end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for iir_direct_form_two; directed corner samples,
// then random coefficient sets and samples under varying idle/stall mixes.
// Depends on idf2_pkg, idf2_in_if, idf2_out_if and tb/idf2_checker.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idf2_pkg::*;

    typedef enum int {SET_FIR, SET_STABLE, SET_WILD, SET_RESONANT} t_coef_kind;

    localparam t_reg_idx REG_NONE = 3'd7;   // unmapped, writes must be ignored
    localparam int ONE_Q20         = 1048576;
    localparam int SETTLE_CYC      = 16;
    localparam int SAMPLES_PER_SET = 175;
    localparam int NUM_SETS        = 8;
    localparam logic signed [SMP_W-1:0] SMP_HI = 24'sh7FFFFF;
    localparam logic signed [SMP_W-1:0] SMP_LO = 24'sh800000;
    localparam t_coef COEF_HI = 24'sh7FFFFF;
    localparam t_coef COEF_LO = 24'sh800000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_reg_idx          i_cfg_idx;
    logic [COEF_W-1:0] i_cfg_data;

    int send_idle_pct;
    int stall_pct;
    int sent_cnt;
    int set_cnt;
    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_clipped;

    int send_idle_tab [0:3] = '{0, 45, 0, 11};
    int stall_tab     [0:3] = '{0, 0, 45, 11};

    idf2_in_if  smp_in ();
    idf2_out_if smp_out ();

    iir_direct_form_two u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_in),
        .o_smp      (smp_out)
    );

    idf2_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (smp_in.valid),
        .i_in_ready    (smp_in.ready),
        .i_in_sample   (smp_in.sample_in),
        .i_out_valid   (smp_out.valid),
        .i_out_ready   (smp_out.ready),
        .i_out_sample  (smp_out.sample_out),
        .i_out_clipped (smp_out.clipped),
        .o_errors      (chk_errors),
        .o_pending     (chk_pending),
        .o_checked     (chk_checked),
        .o_clipped     (chk_clipped)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        smp_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            smp_out.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #1_000_000;
        $display("%0t: timed out", $time);
        $display("iir_direct_form_two regression: fail");
        $finish;
    end

    function automatic int rand_in(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return SMP_HI;
                    1: return SMP_LO;
                    2: return '0;
                    3: return 24'sd1;
                    default: return -24'sd1;
                endcase
            end
            1, 2, 3: return SMP_W'(rand_in(-4096, 4095));
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic void make_coefs(input t_coef_kind kind, output t_coef taps [0:6]);
        foreach (taps[k]) taps[k] = '0;
        case (kind)
            SET_FIR: begin
                for (int k = REG_B0; k <= REG_B3; k++)
                    taps[k] = COEF_W'(rand_in(-ONE_Q20, ONE_Q20));
            end
            SET_STABLE: begin
                for (int k = REG_B0; k <= REG_B3; k++)
                    taps[k] = COEF_W'(rand_in(-ONE_Q20, ONE_Q20));
                // sum of |a| below one keeps the recursion bounded
                taps[REG_A1] = COEF_W'(rand_in(-ONE_Q20 / 2, ONE_Q20 / 2));
                taps[REG_A2] = COEF_W'(rand_in(-ONE_Q20 / 4, ONE_Q20 / 4));
                taps[REG_A3] = COEF_W'(rand_in(-ONE_Q20 / 8, ONE_Q20 / 8));
            end
            SET_WILD: begin
                foreach (taps[k]) taps[k] = t_coef'($urandom);
            end
            default: begin
                // two-pole resonator close to the unit circle
                for (int k = REG_B0; k <= REG_B3; k++)
                    taps[k] = COEF_W'(rand_in(-52429, 52429));
                taps[REG_A1] = COEF_W'(-rand_in(1887437, 2086666));
                taps[REG_A2] = COEF_W'(rand_in(943718, 1038090));
                taps[REG_A3] = COEF_W'(rand_in(-4096, 4096));
            end
        endcase
    endfunction

    // Only called with the block drained
    task automatic load_coefs(input t_coef taps [0:6]);
        for (int k = REG_B0; k <= REG_A3; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(k);
            i_cfg_data <= taps[k];
            @(posedge i_clk);
        end
        if ($urandom_range(1)) begin
            i_cfg_idx  <= REG_NONE;
            i_cfg_data <= COEF_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        set_cnt++;
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_in.valid     <= 1'b1;
        smp_in.sample_in <= x;
        do @(posedge i_clk); while (!smp_in.ready);
        sent_cnt++;
    endtask

    // Valid drops on the step of the last request; wait for every result
    task automatic drain();
        smp_in.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    initial begin
        t_coef taps [0:6];
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_B0;
        i_cfg_data       = '0;
        smp_in.valid     = 1'b0;
        smp_in.sample_in = '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        sent_cnt         = 0;
        set_cnt          = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset taps: unity gain
        send_sample(SMP_HI);
        send_sample(SMP_LO);
        send_sample('0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        drain();

        // largest gain: output saturation and rounding of tiny inputs
        taps = '{COEF_HI, '0, '0, '0, '0, '0, '0};
        load_coefs(taps);
        send_sample(SMP_HI);
        send_sample(SMP_LO);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        drain();

        // half gain: exact halves round toward plus infinity
        taps = '{COEF_W'(ONE_Q20 / 2), '0, '0, '0, '0, '0, '0};
        load_coefs(taps);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sd3);
        send_sample(-24'sd3);
        drain();

        // extreme taps everywhere: delay line saturates within a few samples
        taps = '{COEF_LO, COEF_HI, COEF_LO, COEF_HI, COEF_LO, COEF_HI, COEF_LO};
        load_coefs(taps);
        repeat (4) send_sample(SMP_HI);
        repeat (3) send_sample(SMP_LO);
        drain();

        for (int s = 0; s < NUM_SETS; s++) begin
            make_coefs(t_coef_kind'((s / 2) % 4), taps);
            load_coefs(taps);
            send_idle_pct = send_idle_tab[s % 4];
            stall_pct     = stall_tab[s % 4];
            repeat (SAMPLES_PER_SET) send_sample(pick_sample());
            drain();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("%0d samples sent through %0d coefficient sets (directed and random)",
                 sent_cnt, set_cnt);
        $display("%0d results checked, %0d of them saturated", chk_checked, chk_clipped);
        if (chk_errors == 0 && chk_pending == 0)
            $display("iir_direct_form_two regression: pass");
        else
            $display("iir_direct_form_two regression: fail");
        $finish;
    end

endmodule

/* iir_direct_form_two.f */
design/idf2_pkg.sv
design/idf2_in_if.sv
design/idf2_out_if.sv
design/idf2_mac.sv
design/iir_direct_form_two.sv
tb/idf2_checker.sv
tb/tb.sv
